[sv/mss_pkg.sv]
package mss_pkg;

    // field widths fixed by the item formats
    localparam int VALUE_W = 16;
    localparam int STOP_W  = 16;
    localparam int SUM_W   = 31;

    // default sequence length limit
    localparam int unsigned MAX_ITEMS_DEF = 32767;

    // saturation ceiling of the running sum
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // one input item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic              found;
        logic [STOP_W-1:0] start_stop;
        logic [STOP_W-1:0] end_stop;
        logic [SUM_W-1:0]  best_sum;
    } out_item_t;

endpackage

[sv/mss_in_stage.sv]
module mss_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mss_pkg::in_item_t  s_item,
    output logic               valid,
    output mss_pkg::in_item_t  item,
    input  logic               pop
);

    logic              valid_reg;
    logic              valid_next;
    mss_pkg::in_item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || pop;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

[sv/mss_kadane.sv]
module mss_kadane #(
    parameter int unsigned MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  mss_pkg::in_item_t  item,
    output mss_pkg::out_item_t result
);

    localparam int IDX_W = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W = (IDX_W + 1 > mss_pkg::STOP_W) ? IDX_W + 1 : mss_pkg::STOP_W;
    localparam int ACC_W = mss_pkg::SUM_W + 2;

    logic [mss_pkg::SUM_W-1:0] run_sum_reg, run_sum_next;
    logic [mss_pkg::SUM_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]          best_begin_reg, best_begin_next;
    logic [IDX_W-1:0]          best_end_reg, best_end_next;
    logic [IDX_W-1:0]          run_begin_reg, run_begin_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      seen_reg, seen_next;

    logic                      active;
    logic [IDX_W-1:0]          idx_inc;
    logic signed [ACC_W-1:0]   sum_raw;
    logic signed [ACC_W-1:0]   sum_sat;
    logic signed [ACC_W-1:0]   best_ext;
    logic                      take;
    logic [EXT_W-1:0]          start_ext;
    logic [EXT_W-1:0]          end_ext;

    // one step of the running-sum update
    always_comb begin
        active   = idx_reg < IDX_W'(MAX_ITEMS);
        idx_inc  = idx_reg + IDX_W'(1);
        sum_raw  = $signed({2'b00, run_sum_reg})
                 + ACC_W'(item.value);
        sum_sat  = (sum_raw > $signed({2'b00, mss_pkg::SUM_MAX}))
                 ? $signed({2'b00, mss_pkg::SUM_MAX}) : sum_raw;
        best_ext = $signed({2'b00, best_reg});
        take     = (best_ext < sum_sat)
                || ((best_ext == sum_sat)
                    && ((best_end_reg - best_begin_reg) < (idx_inc - run_begin_reg)));

        run_sum_next    = run_sum_reg;
        best_next       = best_reg;
        best_begin_next = best_begin_reg;
        best_end_next   = best_end_reg;
        run_begin_next  = run_begin_reg;
        idx_next        = idx_reg;
        seen_next       = seen_reg;

        if (active) begin
            idx_next = idx_inc;
            if (!item.value[mss_pkg::VALUE_W-1] && (item.value != '0)) begin
                seen_next = 1'b1;
            end
            if (take) begin
                best_next       = sum_sat[mss_pkg::SUM_W-1:0];
                best_begin_next = run_begin_reg;
                best_end_next   = idx_inc;
            end
            if (sum_sat[ACC_W-1]) begin
                run_sum_next   = '0;
                run_begin_next = idx_inc;
            end else begin
                run_sum_next = sum_sat[mss_pkg::SUM_W-1:0];
            end
        end
    end

    // result from the updated state, zero when nothing was positive
    always_comb begin
        start_ext = EXT_W'(best_begin_next) + EXT_W'(1);
        end_ext   = EXT_W'(best_end_next) + EXT_W'(1);
        result    = '0;
        if (seen_next) begin
            result.found      = 1'b1;
            result.start_stop = start_ext[mss_pkg::STOP_W-1:0];
            result.end_stop   = end_ext[mss_pkg::STOP_W-1:0];
            result.best_sum   = best_next;
        end
    end

    // state registers, cleared after the last item of a sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg    <= '0;
            best_reg       <= '0;
            best_begin_reg <= '0;
            best_end_reg   <= '0;
            run_begin_reg  <= '0;
            idx_reg        <= '0;
            seen_reg       <= 1'b0;
        end else if (fire) begin
            if (item.last) begin
                run_sum_reg    <= '0;
                best_reg       <= '0;
                best_begin_reg <= '0;
                best_end_reg   <= '0;
                run_begin_reg  <= '0;
                idx_reg        <= '0;
                seen_reg       <= 1'b0;
            end else begin
                run_sum_reg    <= run_sum_next;
                best_reg       <= best_next;
                best_begin_reg <= best_begin_next;
                best_end_reg   <= best_end_next;
                run_begin_reg  <= run_begin_next;
                idx_reg        <= idx_next;
                seen_reg       <= seen_next;
            end
        end
    end

    // a closing item leaves a fresh sequence
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last |=> (idx_reg == '0) && (run_sum_reg == '0) && !seen_reg)
        else $error("state not cleared after last item");

    // the index only moves on a processed item
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(idx_reg) && $stable(best_reg))
        else $error("state changed without an item");

    // best segment lies inside the items seen so far
    a_best_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_begin_reg <= best_end_reg) && (best_end_reg <= idx_reg)
        && (run_begin_reg <= idx_reg))
        else $error("segment bounds out of order");

    // index never passes the limit
    a_idx_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(MAX_ITEMS))
        else $error("item index beyond limit");

endmodule

[sv/mss_out_stage.sv]
module mss_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mss_pkg::out_item_t  result,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output mss_pkg::out_item_t  m_item
);

    logic               valid_reg;
    logic               valid_next;
    mss_pkg::out_item_t item_reg;

    // slot is usable when empty or being drained
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

[sv/max_subarray_stream.sv]
// Streaming maximum-sum segment finder.
// Input channel (s_valid/s_ready/s_item): one signed value per item, with a
// last flag on the final item of a sequence. Items are numbered from 1.
// Result channel (m_valid/m_ready/m_item): one item per sequence, produced by
// the last item: found flag, 1-based start and end stops of the best
// segment and its sum, saturated at 2^31-1. With no positive value the
// result carries found = 0 and zero fields.
// Throughput: one item per cycle, except while a last item waits for the result
// register; set by the state update between the input and state registers.
// Result path: a last item passes the input register and then the result
// register (two register stages) before its result shows on m_item.
// Values past MAX_ITEMS in one sequence are ignored; their last flag still
// closes the sequence.
// Reset (aresetn low, synchronous) empties both stages and clears the state.
// When the receiver stalls, values keep flowing; a last item waits in the
// input register until the result register is free, and s_ready drops.
module max_subarray_stream #(
    parameter int unsigned MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mss_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mss_pkg::out_item_t  m_item
);

    logic               in_valid;
    mss_pkg::in_item_t  in_item;
    logic               out_free;
    logic               proc_fire;
    logic               push;
    mss_pkg::out_item_t result;

    // an item is processed unless it closes a sequence and the result slot is busy
    assign proc_fire = in_valid && (!in_item.last || out_free);
    assign push      = proc_fire && in_item.last;

    mss_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .valid   (in_valid),
        .item    (in_item),
        .pop     (proc_fire)
    );

    mss_kadane #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .item    (in_item),
        .result  (result)
    );

    mss_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
